### sv/bounded_deque_remove_matching_defines.svh
// Assertion macros shared by the deque checker.
// Depends on nothing; included by the checker file only.
`ifndef BOUNDED_DEQUE_REMOVE_MATCHING_DEFINES_SVH
`define BOUNDED_DEQUE_REMOVE_MATCHING_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deque assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BDQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deque assertion failed");

`endif

### sv/bdq_pkg.sv
// Types and codes of the bounded deque.
// Depends on nothing; used by every other file but the defines header.
package bdq_pkg;

    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 5;

    typedef enum logic [1:0] {
        REQ_PUSH       = 2'd0,
        REQ_POP_HEAD   = 2'd1,
        REQ_POP_TAIL   = 2'd2,
        REQ_REMOVE_ALL = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_FIN
    } t_state;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

endpackage

### sv/bdq_if.sv
// Request and response channel interfaces of the bounded deque.
// Depends on bdq_pkg for field widths.
interface bdq_req_if;
    logic                                valid;
    logic                                ready;
    logic [1:0]                          req_type;
    logic signed [bdq_pkg::DATA_W-1:0]   value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

interface bdq_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [bdq_pkg::COUNT_W-1:0]        removed_count;
    logic [bdq_pkg::COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output removed_count,
                    output entry_count, input ready);
    modport sink (input valid, input status, input removed_count,
                  input entry_count, output ready);
endinterface

### sv/bounded_deque_remove_matching.sv
// Bounded deque of signed 32-bit entries with remove-all-matching.
// Depends on bdq_pkg, bdq_if, bdq_cell and bdq_ctrl.
//
// Requests arrive on i_req (req_type, value) and each gives exactly one
// response word on o_rsp (status, removed_count, entry_count), both with
// a valid/ready handshake. Entries sit in a row of CAPACITY cells with
// the head in cell 0; a pop from the head shifts the whole row by one.
// Push, pop head and pop tail answer in the cycle after acceptance, and
// the next request can be taken in the cycle that word is taken, so
// these run at one word per cycle while the receiver is ready. A
// remove-all on a list of N entries rotates the row once per cycle,
// dropping matches as they leave the head, and answers from S_FIN once
// all N entries have passed the head. A remove-all on an empty list
// answers in the cycle after acceptance, as a push does. Reset clears
// the length to zero; cell contents are not cleared and are only ever
// read after being written. While the receiver holds a response word,
// no new request is accepted and the held word stays unchanged.
module bounded_deque_remove_matching #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    localparam int unsigned LW = $clog2(CAPACITY + 1);

    logic signed [bdq_pkg::DATA_W-1:0] w_val [CAPACITY];
    bdq_pkg::t_cell_ctl                w_ctl;
    logic [LW-1:0]                     w_pos;
    logic signed [bdq_pkg::DATA_W-1:0] w_load_data;

    bdq_ctrl #(
        .CAPACITY (CAPACITY),
        .LW       (LW)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .i_req_type    (i_req.req_type),
        .i_req_value   (i_req.value),
        .o_req_ready   (i_req.ready),
        .i_rsp_ready   (o_rsp.ready),
        .o_rsp_valid   (o_rsp.valid),
        .o_rsp_status  (o_rsp.status),
        .o_rsp_removed (o_rsp.removed_count),
        .o_rsp_count   (o_rsp.entry_count),
        .i_head        (w_val[0]),
        .o_ctl         (w_ctl),
        .o_pos         (w_pos),
        .o_load_data   (w_load_data)
    );

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        bdq_cell #(
            .IDX (gi),
            .LW  (LW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_pos       (w_pos),
            .i_load_data (w_load_data),
            .i_nbr       (w_val[(gi + 1 < CAPACITY) ? gi + 1 : gi]),
            .o_val       (w_val[gi])
        );
    end

endmodule

### sv/bdq_cell.sv
// One storage cell of the deque chain: holds one entry, takes its
// right-hand neighbour on a shift or the broadcast word on a load at its own position.
// Depends on bdq_pkg.
module bdq_cell #(
    parameter int unsigned IDX = 0,
    parameter int unsigned LW  = 5
) (
    input  logic                              i_clk,
    input  bdq_pkg::t_cell_ctl                i_ctl,
    input  logic [LW-1:0]                     i_pos,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_load_data,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_nbr,
    output logic signed [bdq_pkg::DATA_W-1:0] o_val
);

    logic signed [bdq_pkg::DATA_W-1:0] r_val;
    logic                              w_hit;

    assign w_hit = i_ctl.load && (i_pos == LW'(IDX));

    always_ff @(posedge i_clk) begin
        if (w_hit) begin
            r_val <= i_load_data;
        end else if (i_ctl.shift) begin
            r_val <= i_nbr;
        end
    end

    assign o_val = r_val;

endmodule

### sv/bdq_ctrl.sv
// Sequencer of the deque: length, request decode, rotation sweep for
// remove-all and the registered response word.
// Depends on bdq_pkg.
module bdq_ctrl #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned LW       = 5
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_req_valid,
    input  logic [1:0]                        i_req_type,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_req_value,
    output logic                              o_req_ready,
    input  logic                              i_rsp_ready,
    output logic                              o_rsp_valid,
    output logic [1:0]                        o_rsp_status,
    output logic [bdq_pkg::COUNT_W-1:0]       o_rsp_removed,
    output logic [bdq_pkg::COUNT_W-1:0]       o_rsp_count,
    input  logic signed [bdq_pkg::DATA_W-1:0] i_head,
    output bdq_pkg::t_cell_ctl                o_ctl,
    output logic [LW-1:0]                     o_pos,
    output logic signed [bdq_pkg::DATA_W-1:0] o_load_data
);

    localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);
    localparam logic [LW-1:0] ONE_L = LW'(1);

    bdq_pkg::t_state                   r_state, n_state;
    logic [LW-1:0]                     r_len, n_len;
    logic [LW-1:0]                     r_cnt, n_cnt;
    logic [LW-1:0]                     r_orig, n_orig;
    logic signed [bdq_pkg::DATA_W-1:0] r_key, n_key;
    logic                              r_out_valid, n_out_valid;
    bdq_pkg::t_status                  r_status, n_status;
    logic [bdq_pkg::COUNT_W-1:0]       r_removed, n_removed;
    logic [bdq_pkg::COUNT_W-1:0]       r_count, n_count;
    logic                              w_out_free;
    logic                              w_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bdq_pkg::S_IDLE;
            r_len       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_orig    <= n_orig;
        r_key     <= n_key;
        r_status  <= n_status;
        r_removed <= n_removed;
        r_count   <= n_count;
    end

    assign w_out_free  = !r_out_valid || i_rsp_ready;
    assign o_req_ready = (r_state == bdq_pkg::S_IDLE) && w_out_free;
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        n_state     = r_state;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_orig      = r_orig;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_rsp_ready;
        n_status    = r_status;
        n_removed   = r_removed;
        n_count     = r_count;
        o_ctl       = '0;
        o_pos       = r_len;
        o_load_data = i_req_value;

        case (r_state)
            bdq_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::ST_OK;
                    n_removed   = '0;
                    case (bdq_pkg::t_req_type'(i_req_type))
                        bdq_pkg::REQ_PUSH: begin
                            if (r_len == CAP_L) begin
                                n_status = bdq_pkg::ST_FULL;
                            end else begin
                                o_ctl.load = 1'b1;
                                n_len      = r_len + ONE_L;
                            end
                        end
                        bdq_pkg::REQ_POP_HEAD: begin
                            if (r_len == '0) begin
                                n_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                o_ctl.shift = 1'b1;
                                n_len       = r_len - ONE_L;
                                n_removed   = bdq_pkg::COUNT_W'(1);
                            end
                        end
                        bdq_pkg::REQ_POP_TAIL: begin
                            if (r_len == '0) begin
                                n_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_len     = r_len - ONE_L;
                                n_removed = bdq_pkg::COUNT_W'(1);
                            end
                        end
                        default: begin
                            if (r_len == '0) begin
                                n_status = bdq_pkg::ST_EMPTY;
                            end else begin
                                n_out_valid = 1'b0;
                                n_state     = bdq_pkg::S_SWEEP;
                                n_cnt       = r_len;
                                n_orig      = r_len;
                                n_key       = i_req_value;
                            end
                        end
                    endcase
                    n_count = bdq_pkg::COUNT_W'(n_len);
                end
            end
            bdq_pkg::S_SWEEP: begin
                o_ctl.shift = 1'b1;
                o_load_data = i_head;
                o_pos       = r_len - ONE_L;
                if (i_head == r_key) begin
                    n_len = r_len - ONE_L;
                end else begin
                    o_ctl.load = 1'b1;
                end
                n_cnt = r_cnt - ONE_L;
                if (r_cnt == ONE_L) begin
                    n_state = bdq_pkg::S_FIN;
                end
            end
            bdq_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = bdq_pkg::ST_OK;
                    n_removed   = bdq_pkg::COUNT_W'(r_orig - r_len);
                    n_count     = bdq_pkg::COUNT_W'(r_len);
                    n_state     = bdq_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bdq_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rsp_valid   = r_out_valid;
    assign o_rsp_status  = r_status;
    assign o_rsp_removed = r_removed;
    assign o_rsp_count   = r_count;

endmodule

### sv/bdq_checker.sv
// Port-level checker for the bounded deque and its bind to the top level.
// Depends on bdq_pkg and bounded_deque_remove_matching_defines.svh.
`include "bounded_deque_remove_matching_defines.svh"

module bdq_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_req_valid,
    input logic       i_req_ready,
    input logic       i_rsp_valid,
    input logic       i_rsp_ready,
    input logic [1:0] i_rsp_status,
    input logic [4:0] i_rsp_removed,
    input logic [4:0] i_rsp_count
);

    `BDQ_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_removed) && $stable(i_rsp_count))

    `BDQ_ASSERT_IMPLY(a_no_accept_while_held, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, !(i_req_valid && i_req_ready))

    `BDQ_ASSERT_IMPLY(a_empty_word, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == bdq_pkg::ST_EMPTY), (i_rsp_removed == 5'd0) && (i_rsp_count == 5'd0))

    `BDQ_ASSERT_IMPLY(a_full_word, i_clk, i_rst_n, i_rsp_valid && (i_rsp_status == bdq_pkg::ST_FULL), (i_rsp_removed == 5'd0) && (i_rsp_count == 5'(CAPACITY)))

endmodule

bind bounded_deque_remove_matching bdq_checker #(
    .CAPACITY (CAPACITY)
) u_bdq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_status  (o_rsp.status),
    .i_rsp_removed (o_rsp.removed_count),
    .i_rsp_count   (o_rsp.entry_count)
);
